[src/cmpm_pkg.sv]
// Shared types and constants for the console memory page mapper.
`timescale 1ns / 1ps
`default_nettype none
package cmpm_pkg;

    localparam int BANK_BITS   = 8;
    localparam int ADDR_W      = 16;
    localparam int CTRL_W      = 8;
    localparam int BANK_W      = 8;
    localparam int OFFSET_W    = 22;
    localparam int ROM_LEN_W   = 23;
    localparam int PAGE_SHIFT  = 14;

    localparam logic [ROM_LEN_W-1:0] ROM_LENGTH_RESET = ROM_LEN_W'(262144);
    localparam logic [ROM_LEN_W-1:0] PAGE_SIZE        = ROM_LEN_W'(1) << PAGE_SHIFT;

    localparam int CTRL_BRAM_EN_BIT = 3;
    localparam int CTRL_BRAM_HI_BIT = 2;

    typedef enum logic [1:0] {
        REGION_ROM  = 2'd0,
        REGION_WRAM = 2'd1,
        REGION_BRAM = 2'd2
    } cmpm_region_t;

    typedef struct packed {
        logic                 valid;
        cmpm_region_t         region;
        logic                 wr;
        logic [OFFSET_W-1:0]  low;
        logic [BANK_BITS-1:0] bank;
        logic                 done;
        logic [BANK_BITS-1:0] page;
    } cmpm_item_t;

endpackage
`default_nettype wire

[src/cmpm_fold_cell.sv]
// One bank-folding cell: tries one mask width and passes the transaction on.
`timescale 1ns / 1ps
`default_nettype none
module cmpm_fold_cell (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  en,
    input  wire logic [cmpm_pkg::BANK_BITS-1:0]        mask,
    input  wire logic [cmpm_pkg::ROM_LEN_W-1:0]        rom_length,
    input  wire cmpm_pkg::cmpm_item_t                  item_in,
    output cmpm_pkg::cmpm_item_t                       item_out
);

    cmpm_pkg::cmpm_item_t                 item_reg;
    cmpm_pkg::cmpm_item_t                 item_next;
    logic [cmpm_pkg::BANK_BITS-1:0]       masked;
    logic [cmpm_pkg::ROM_LEN_W-1:0]       page_end;
    logic                                 fits;

    always_comb begin
        masked    = item_in.bank & mask;
        page_end  = cmpm_pkg::ROM_LEN_W'({1'b0, masked} + (cmpm_pkg::BANK_BITS+1)'(1))
                    << cmpm_pkg::PAGE_SHIFT;
        fits      = (page_end <= rom_length);
        item_next = item_in;
        if (!item_in.done && fits) begin
            item_next.done = 1'b1;
            item_next.page = masked;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_reg.valid <= 1'b0;
        end else if (en) begin
            item_reg <= item_next;
        end
    end

    assign item_out = item_reg;

endmodule
`default_nettype wire

[src/console_memory_page_mapper_core.sv]
// Top level of the console memory page mapper.
// Translates each CPU address into region, byte offset and write permission.
// Takes one transaction per cycle while the output is not stalled; a result
// passes the chain of folding cells, one cell per mask width from BANK_BITS
// bits down to one bit, then the output register. A stalled output holds the
// whole chain. The user must write rom_length through cfg_wr_en / cfg_wr_data
// only while no transaction is in flight; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
module console_memory_page_mapper_core (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [cmpm_pkg::ROM_LEN_W-1:0]     cfg_wr_data,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [cmpm_pkg::ADDR_W-1:0]        s_address,
    input  wire logic [cmpm_pkg::CTRL_W-1:0]        s_mapper_control,
    input  wire logic [cmpm_pkg::BANK_W-1:0]        s_window0_bank,
    input  wire logic [cmpm_pkg::BANK_W-1:0]        s_window1_bank,
    input  wire logic [cmpm_pkg::BANK_W-1:0]        s_window2_bank,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [1:0]                              m_region,
    output logic [cmpm_pkg::OFFSET_W-1:0]           m_offset,
    output logic                                    m_write_allowed
);

    localparam int NCELL = cmpm_pkg::BANK_BITS;

    logic [cmpm_pkg::ROM_LEN_W-1:0] rom_length_reg;
    logic                           en;
    cmpm_pkg::cmpm_item_t           entry;
    cmpm_pkg::cmpm_item_t           chain [NCELL+1];

    logic                           m_valid_reg;
    cmpm_pkg::cmpm_region_t         m_region_reg;
    logic [cmpm_pkg::OFFSET_W-1:0]  m_offset_reg;
    logic                           m_wr_reg;
    logic [cmpm_pkg::OFFSET_W-1:0]  offset_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rom_length_reg <= cmpm_pkg::ROM_LENGTH_RESET;
        end else if (cfg_wr_en) begin
            rom_length_reg <= cfg_wr_data;
        end
    end

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    always_comb begin
        entry        = '0;
        entry.valid  = s_valid;
        entry.region = cmpm_pkg::REGION_ROM;
        entry.low    = cmpm_pkg::OFFSET_W'(s_address[13:0]);
        unique case (s_address[15:14])
            2'b00: begin
                if (s_address[13:10] == 4'd0) begin
                    entry.low = cmpm_pkg::OFFSET_W'(s_address);
                end else begin
                    entry.bank = s_window0_bank[cmpm_pkg::BANK_BITS-1:0];
                end
            end
            2'b01: begin
                entry.bank = s_window1_bank[cmpm_pkg::BANK_BITS-1:0];
            end
            2'b10: begin
                if (s_mapper_control[cmpm_pkg::CTRL_BRAM_EN_BIT]) begin
                    entry.region = cmpm_pkg::REGION_BRAM;
                    entry.wr     = 1'b1;
                    entry.low    = cmpm_pkg::OFFSET_W'(
                        {s_mapper_control[cmpm_pkg::CTRL_BRAM_HI_BIT], 13'd0})
                        + cmpm_pkg::OFFSET_W'(s_address[13:0]);
                end else begin
                    entry.bank = s_window2_bank[cmpm_pkg::BANK_BITS-1:0];
                end
            end
            default: begin
                entry.region = cmpm_pkg::REGION_WRAM;
                entry.low    = cmpm_pkg::OFFSET_W'(s_address[12:0]);
                entry.wr     = !(s_address[15:8] == 8'hFF);
            end
        endcase
    end

    assign chain[0] = entry;

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        localparam logic [cmpm_pkg::BANK_BITS-1:0] CELL_MASK =
            cmpm_pkg::BANK_BITS'((1 << (NCELL - g)) - 1);
        cmpm_fold_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .en         (en),
            .mask       (CELL_MASK),
            .rom_length (rom_length_reg),
            .item_in    (chain[g]),
            .item_out   (chain[g+1])
        );
    end

    always_comb begin
        offset_next = chain[NCELL].low;
        if (chain[NCELL].done) begin
            offset_next = chain[NCELL].low
                        | (cmpm_pkg::OFFSET_W'(chain[NCELL].page) << cmpm_pkg::PAGE_SHIFT);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg  <= chain[NCELL].valid;
            m_region_reg <= chain[NCELL].region;
            m_offset_reg <= offset_next;
            m_wr_reg     <= chain[NCELL].wr;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_region        = m_region_reg;
    assign m_offset        = m_offset_reg;
    assign m_write_allowed = m_wr_reg;

    a_wr_not_rom: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_write_allowed) |-> (m_region != cmpm_pkg::REGION_ROM))
        else $error("write allowed on ROM region");

    a_rom_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_region == cmpm_pkg::REGION_ROM
         && rom_length_reg >= cmpm_pkg::PAGE_SIZE)
        |-> (cmpm_pkg::ROM_LEN_W'(m_offset) < rom_length_reg))
        else $error("ROM offset beyond ROM length");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_wram_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_region == cmpm_pkg::REGION_WRAM) |-> (m_offset[21:13] == 9'd0))
        else $error("work RAM offset outside 8 KB");

endmodule
`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench for console_memory_page_mapper_core address translation.
`timescale 1ns / 1ps
module tb_top;
    import cmpm_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 2 * (BANK_BITS + 1);
    localparam int PHASE_ITEMS    = 125;
    localparam int NUM_PHASES     = 9;

    typedef struct {
        cmpm_region_t        region;
        logic [OFFSET_W-1:0] offset;
        logic                write_allowed;
    } translation_t;

    class page_map_scoreboard;
        logic [ROM_LEN_W-1:0] rom_length;
        translation_t         expected_translations[$];
        int unsigned          mismatch_count;

        function new();
            rom_length = ROM_LENGTH_RESET;
            mismatch_count = 0;
        endfunction

        function void set_rom_length(logic [ROM_LEN_W-1:0] value);
            rom_length = value;
        endfunction

        function int unsigned pending();
            return expected_translations.size();
        endfunction

        // halve the bank mask until the page fits inside the ROM
        function logic [OFFSET_W-1:0] folded_page_base(logic [BANK_W-1:0] bank);
            int unsigned mask;
            int unsigned base;
            mask = (1 << BANK_BITS) - 1;
            for (int i = 0; i <= BANK_BITS; i++) begin
                base = (32'(bank) & mask) << PAGE_SHIFT;
                if (base + 32'(PAGE_SIZE) <= 32'(rom_length)) begin
                    return OFFSET_W'(base);
                end
                mask = mask >> 1;
            end
            return '0;
        endfunction

        function translation_t translate_address(logic [ADDR_W-1:0] addr,
                                                 logic [CTRL_W-1:0] ctrl,
                                                 logic [BANK_W-1:0] b0,
                                                 logic [BANK_W-1:0] b1,
                                                 logic [BANK_W-1:0] b2);
            translation_t t;
            t.region = REGION_ROM;
            t.offset = '0;
            t.write_allowed = 1'b0;
            if (addr < 16'h0400) begin
                t.offset = OFFSET_W'(addr);
            end else if (addr < 16'h4000) begin
                t.offset = folded_page_base(b0) + OFFSET_W'(addr);
            end else if (addr < 16'h8000) begin
                t.offset = folded_page_base(b1) + OFFSET_W'(addr - 16'h4000);
            end else if (addr < 16'hC000) begin
                if (ctrl[CTRL_BRAM_EN_BIT]) begin
                    t.region = REGION_BRAM;
                    t.offset = (ctrl[CTRL_BRAM_HI_BIT] ? 22'h2000 : 22'h0)
                             + OFFSET_W'(addr - 16'h8000);
                    t.write_allowed = 1'b1;
                end else begin
                    t.offset = folded_page_base(b2) + OFFSET_W'(addr - 16'h8000);
                end
            end else if (addr < 16'hE000) begin
                t.region = REGION_WRAM;
                t.offset = OFFSET_W'(addr - 16'hC000);
                t.write_allowed = 1'b1;
            end else begin
                t.region = REGION_WRAM;
                t.offset = OFFSET_W'(addr - 16'hE000);
                t.write_allowed = (addr < 16'hFF00);
            end
            return t;
        endfunction

        function void note_input(logic [ADDR_W-1:0] addr, logic [CTRL_W-1:0] ctrl,
                                 logic [BANK_W-1:0] b0, logic [BANK_W-1:0] b1,
                                 logic [BANK_W-1:0] b2);
            expected_translations.push_back(translate_address(addr, ctrl, b0, b1, b2));
        endfunction

        function void check_result(logic [1:0] region, logic [OFFSET_W-1:0] offset,
                                   logic write_allowed);
            translation_t want;
            if (expected_translations.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result: region=%0d offset=0x%06h write=%0b",
                             region, offset, write_allowed);
                end
                return;
            end
            want = expected_translations.pop_front();
            if (region !== want.region || offset !== want.offset ||
                write_allowed !== want.write_allowed) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("mismatch: expected region=%0d offset=0x%06h write=%0b, %s",
                             want.region, want.offset, want.write_allowed,
                             $sformatf("got region=%0d offset=0x%06h write=%0b",
                                       region, offset, write_allowed));
                end
            end
        endfunction

        function bit all_matched();
            if (expected_translations.size() != 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("%0d translations never arrived", expected_translations.size());
                end
            end
            return mismatch_count == 0;
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [ROM_LEN_W-1:0] cfg_wr_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [ADDR_W-1:0]    s_address = '0;
    logic [CTRL_W-1:0]    s_mapper_control = '0;
    logic [BANK_W-1:0]    s_window0_bank = '0;
    logic [BANK_W-1:0]    s_window1_bank = '0;
    logic [BANK_W-1:0]    s_window2_bank = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [1:0]           m_region;
    logic [OFFSET_W-1:0]  m_offset;
    logic                 m_write_allowed;

    int unsigned sender_idle_pct = 36;
    int unsigned receiver_idle_pct = 64;

    page_map_scoreboard sb;

    console_memory_page_mapper_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_address       (s_address),
        .s_mapper_control(s_mapper_control),
        .s_window0_bank  (s_window0_bank),
        .s_window1_bank  (s_window1_bank),
        .s_window2_bank  (s_window2_bank),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_region        (m_region),
        .m_offset        (m_offset),
        .m_write_allowed (m_write_allowed)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_region, m_offset, m_write_allowed);
        end
    end

    initial begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("console_memory_page_mapper_core regression: fail");
        $finish;
    end

    // enter and leave at a falling edge
    task automatic send_item(input logic [ADDR_W-1:0] addr, input logic [CTRL_W-1:0] ctrl,
                             input logic [BANK_W-1:0] b0, input logic [BANK_W-1:0] b1,
                             input logic [BANK_W-1:0] b2);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_address        <= addr;
        s_mapper_control <= ctrl;
        s_window0_bank   <= b0;
        s_window1_bank   <= b1;
        s_window2_bank   <= b2;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        sb.note_input(addr, ctrl, b0, b1, b2);
        @(negedge aclk);
    endtask

    function automatic logic [BANK_W-1:0] pick_bank();
        return $urandom_range(1) ? BANK_W'($urandom_range(255)) : BANK_W'($urandom_range(31));
    endfunction

    task automatic send_random_item();
        logic [ADDR_W-1:0] addr;
        case ($urandom_range(9))
            0: addr = ADDR_W'($urandom_range(16'h03FF));
            1: addr = ADDR_W'($urandom_range(16'h3FFF, 16'h0400));
            2: addr = ADDR_W'($urandom_range(16'h7FFF, 16'h4000));
            3, 4: addr = ADDR_W'($urandom_range(16'hBFFF, 16'h8000));
            5: addr = ADDR_W'($urandom_range(16'hDFFF, 16'hC000));
            6: addr = ADDR_W'($urandom_range(16'hFEFF, 16'hE000));
            7: addr = ADDR_W'($urandom_range(16'hFFFF, 16'hFF00));
            default: addr = ADDR_W'($urandom_range(16'hFFFF));
        endcase
        send_item(addr, CTRL_W'($urandom_range(255)), pick_bank(), pick_bank(), pick_bank());
    endtask

    task automatic wait_for_drain();
        while (sb.pending() != 0) begin
            @(negedge aclk);
        end
    endtask

    initial begin : stimulus
        logic [ROM_LEN_W-1:0] rom_settings[NUM_PHASES];
        rom_settings = '{23'd0, 23'd16383, 23'd16384, 23'd49152, 23'd4194304,
                         23'd131072, 23'h7FFFFF, 23'd1000000, 23'd262144};
        sb = new();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed pass at the reset ROM length
        send_item(16'h0000, 8'h00, 8'h00, 8'h00, 8'h00);
        send_item(16'h03FF, 8'h00, 8'hFF, 8'hFF, 8'hFF);
        send_item(16'h0400, 8'h00, 8'hFF, 8'h00, 8'h00);
        send_item(16'h3FFF, 8'h00, 8'h10, 8'h00, 8'h00);
        send_item(16'h2000, 8'h00, 8'hAA, 8'h00, 8'h00);
        send_item(16'h4000, 8'h00, 8'h00, 8'h0F, 8'h00);
        send_item(16'h7FFF, 8'h00, 8'h00, 8'hFF, 8'h00);
        send_item(16'h6000, 8'h00, 8'h00, 8'h55, 8'h00);
        send_item(16'h8000, 8'h00, 8'h00, 8'h00, 8'h05);
        send_item(16'hBFFF, 8'h00, 8'h00, 8'h00, 8'hFF);
        send_item(16'hA123, 8'hF7, 8'h00, 8'h00, 8'h80);
        send_item(16'h8000, 8'h08, 8'h00, 8'h00, 8'hFF);
        send_item(16'hBFFF, 8'h0C, 8'h00, 8'h00, 8'hFF);
        send_item(16'h9000, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_item(16'hC000, 8'h00, 8'h00, 8'h00, 8'h00);
        send_item(16'hDFFF, 8'hFF, 8'h00, 8'h00, 8'h00);
        send_item(16'hE000, 8'h00, 8'h00, 8'h00, 8'h00);
        send_item(16'hFEFF, 8'h00, 8'h00, 8'h00, 8'h00);
        send_item(16'hFF00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_item(16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase / 3)
                0: begin
                    sender_idle_pct = 36;
                    receiver_idle_pct = 64;
                end
                1: begin
                    sender_idle_pct = 64;
                    receiver_idle_pct = 36;
                end
                default: begin
                    sender_idle_pct = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            // hold off new transactions until the pipeline is empty
            s_valid <= 1'b0;
            wait_for_drain();
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= rom_settings[phase];
            sb.set_rom_length(rom_settings[phase]);
            @(negedge aclk);
            cfg_wr_en <= 1'b0;
            repeat (PHASE_ITEMS) send_random_item();
        end

        s_valid <= 1'b0;
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.all_matched()) begin
            $display("console_memory_page_mapper_core regression: pass");
        end else begin
            $display("console_memory_page_mapper_core regression: fail");
        end
        $finish;
    end
endmodule
